### rtl/assert_macros.svh
// Assertion macros shared by the root finder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NCR_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define NCR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NCR_ASSERT(lbl, clk, rstn, prop, msg)
`define NCR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/ncr_pkg.sv
// Types, constants and saturating helpers for the Newton cubic root finder.
package ncr_pkg;

	localparam int DW   = 32;             // word width
	localparam int FB   = 16;             // fraction bits
	localparam int QW   = DW + FB;        // divider dividend width
	localparam int CNTW = $clog2(QW);

	typedef struct packed {
		logic signed [DW-1:0] left_end;
		logic signed [DW-1:0] right_end;
	} in_item_t;

	typedef struct packed {
		logic signed [DW-1:0] root;
		logic [1:0]           status;
		logic [5:0]           steps_done;
	} out_item_t;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NOSTART = 2'd1;
	localparam logic [1:0] STAT_FAULT   = 2'd2;

	localparam logic [2:0] REG_CUBIC  = 3'd0;
	localparam logic [2:0] REG_SQUARE = 3'd1;
	localparam logic [2:0] REG_LINEAR = 3'd2;
	localparam logic [2:0] REG_CONST  = 3'd3;
	localparam logic [2:0] REG_MAXIT  = 3'd4;

	localparam logic signed [DW-1:0] RST_CUBIC  = DW'(1) << (FB - 1);
	localparam logic signed [DW-1:0] RST_SQUARE = '0;
	localparam logic signed [DW-1:0] RST_LINEAR = DW'(11) << FB;
	localparam logic signed [DW-1:0] RST_CONST  = -(DW'(99) << (FB - 2));
	localparam logic [5:0]           RST_MAXIT  = 6'd20;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PRO, ST_EVAL, ST_CHECK, ST_LOOP, ST_DIV, ST_SUB, ST_FIN
	} state_t;

	typedef enum logic [1:0] {PH_A, PH_B, PH_X} phase_t;

	typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL} op_t;

	typedef enum logic [3:0] {
		SRC_C3, SRC_C2, SRC_C1, SRC_C0, SRC_X, SRC_T,
		SRC_C3X3, SRC_C2X2, SRC_C6, SRC_Q
	} src_t;

	typedef enum logic [2:0] {
		DST_T, DST_FX, DST_DFX, DST_DDFX, DST_C3X3, DST_C2X2, DST_C6, DST_XN
	} dst_t;

	typedef struct packed {
		op_t  op;
		src_t a;
		src_t b;
		dst_t d;
	} uop_t;

	localparam logic [3:0] PRO_LAST   = 4'd3;
	localparam logic [3:0] EVAL_FIRST = 4'd4;
	localparam logic [3:0] EVAL_LAST  = 4'd15;

	typedef struct packed {
		logic                 sat;
		logic signed [DW-1:0] val;
	} res_t;

	typedef struct packed {
		logic                 done;
		logic                 sat;
		logic signed [DW-1:0] quo;
	} div_res_t;

	function automatic logic [DW-1:0] mag_of(input logic signed [DW-1:0] v);
		return v[DW-1] ? DW'(-v) : DW'(v);
	endfunction

	// clamp a sign and magnitude pair into the signed word range
	function automatic res_t sat_mag(input logic neg, input logic [2*DW-1:0] mag);
		logic [2*DW-1:0] lim;
		logic [2*DW-1:0] m;
		res_t r;
		lim = neg ? ((2*DW)'(1) << (DW - 1)) : (((2*DW)'(1) << (DW - 1)) - 1'b1);
		m = mag;
		r.sat = 1'b0;
		if (m > lim) begin
			r.sat = 1'b1;
			m = lim;
		end
		r.val = neg ? DW'(-m) : DW'(m);
		return r;
	endfunction

	function automatic res_t sat_sum(input logic signed [DW:0] s);
		res_t r;
		r.sat = s[DW] != s[DW-1];
		if (r.sat)
			r.val = s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		else
			r.val = s[DW-1:0];
		return r;
	endfunction

endpackage

### rtl/ncr_div.sv
// Bit-serial restoring divider for signed fixed point quotients.
module ncr_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [ncr_pkg::DW-1:0] num,
	input  logic signed [ncr_pkg::DW-1:0] den,
	output ncr_pkg::div_res_t             res
);

	logic                        busy_q, fin_q, zero_q;
	logic [ncr_pkg::CNTW-1:0]    cnt_q;
	logic [ncr_pkg::QW-1:0]      n_q;
	logic [ncr_pkg::DW-1:0]      rem_q, dm_q;
	logic                        neg_q;
	logic [ncr_pkg::DW:0]        rem_sh, diff;
	logic                        fits;
	ncr_pkg::res_t               fin_res;

	assign rem_sh = {rem_q, n_q[ncr_pkg::QW-1]};
	assign diff   = rem_sh - {1'b0, dm_q};
	assign fits   = rem_sh >= {1'b0, dm_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			zero_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			fin_q  <= den == '0;
			busy_q <= den != '0;
			zero_q <= den == '0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == ncr_pkg::CNTW'(ncr_pkg::QW - 1)) begin
				busy_q <= 1'b0;
				fin_q  <= 1'b1;
			end
		end else begin
			fin_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dm_q  <= ncr_pkg::mag_of(den);
			if (den == '0) begin
				// divide by zero: saturate toward the sign of the numerator
				n_q   <= (num != '0) ? '1 : '0;
				neg_q <= num[ncr_pkg::DW-1];
			end else begin
				n_q   <= {ncr_pkg::mag_of(num), {ncr_pkg::FB{1'b0}}};
				neg_q <= num[ncr_pkg::DW-1] ^ den[ncr_pkg::DW-1];
			end
		end else if (busy_q) begin
			rem_q <= fits ? diff[ncr_pkg::DW-1:0] : rem_sh[ncr_pkg::DW-1:0];
			n_q   <= {n_q[ncr_pkg::QW-2:0], fits};
		end
	end

	assign fin_res  = ncr_pkg::sat_mag(neg_q, (2*ncr_pkg::DW)'(n_q));
	assign res.done = fin_q;
	assign res.sat  = fin_res.sat | zero_q;
	assign res.quo  = fin_res.val;

endmodule

### rtl/newton_cubic_root_finder.sv
// Top level of the Newton root finder for a configurable cubic.
//
// Solves f(x) = c3*x^3 + c2*x^2 + c1*x + c0 in signed Q16.16 by Newton steps
// x' = x - f(x)/f'(x). Each input word carries interval ends a and b; the
// start point is the first of a, b where f and f'' are nonzero with equal
// sign, otherwise status 1 with root 0. Stepping stops after the step whose
// x has f*f'' <= 0, or after max_iterations steps; root is the last x'.
// Any saturation (products, sums, quotient) or a zero derivative gives
// status 2 but stepping goes on. All arithmetic runs through one shared
// add/subtract/multiply unit driven by a micro-op sequencer, plus a
// bit-serial divider. Sequence: coefficient setup micro-ops, then for each
// endpoint evaluated 12 micro-ops and a check, then for each Newton step
// a loop state, 12 micro-ops, a check, a divide wait and the update, plus
// taking the word and handing off the result. The divider and the single
// arithmetic unit set the solve time; steps default to 20. in_stall is high
// for the whole solve. A finished result sits in an output register, so the
// next word is taken while it waits. Coefficient and limit registers are
// written through cfg_we/cfg_index/cfg_wdata; the user must write them only
// while idle, as the block itself does not enforce this.
`include "assert_macros.svh"

module newton_cubic_root_finder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [ncr_pkg::DW-1:0]        cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  ncr_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output ncr_pkg::out_item_t            out_data
);

	localparam int DW = ncr_pkg::DW;

	// configuration
	logic signed [DW-1:0] c3_q, c2_q, c1_q, c0_q;
	logic [5:0]           max_it_q;

	// sequencer
	ncr_pkg::state_t state_q, state_d;
	ncr_pkg::phase_t ph_q;
	logic [3:0]      step_q;
	logic [5:0]      steps_q;
	logic            sat_q, nostart_q;
	logic            out_valid_q;

	// working registers
	logic signed [DW-1:0] x_q, b_q, xn_q, t_q, fx_q, dfx_q, ddfx_q, q_q;
	logic signed [DW-1:0] c3x3_q, c2x2_q, c6_q;
	ncr_pkg::out_item_t   out_q;

	// control strobes
	logic ld_in, alu_wr, take_b, keep_start, no_start, div_start;
	logic iter_next, div_take, sub_wr, out_ld, ss;

	ncr_pkg::uop_t        cur;
	logic signed [DW-1:0] bank [16];
	logic signed [DW-1:0] a_val, b_val;
	logic [2*DW-1:0]      prod;
	ncr_pkg::res_t        alu_res;
	ncr_pkg::div_res_t    div_res;

	function automatic ncr_pkg::uop_t uop_rom(input logic [3:0] s);
		ncr_pkg::uop_t u;
		unique case (s)
			4'd0:  u = '{ncr_pkg::OP_ADD, ncr_pkg::SRC_C3,   ncr_pkg::SRC_C3,   ncr_pkg::DST_T};
			4'd1:  u = '{ncr_pkg::OP_ADD, ncr_pkg::SRC_T,    ncr_pkg::SRC_C3,   ncr_pkg::DST_C3X3};
			4'd2:  u = '{ncr_pkg::OP_ADD, ncr_pkg::SRC_C2,   ncr_pkg::SRC_C2,   ncr_pkg::DST_C2X2};
			4'd3:  u = '{ncr_pkg::OP_ADD, ncr_pkg::SRC_C3X3, ncr_pkg::SRC_C3X3, ncr_pkg::DST_C6};
			4'd4:  u = '{ncr_pkg::OP_MUL, ncr_pkg::SRC_C3,   ncr_pkg::SRC_X,    ncr_pkg::DST_T};
			4'd5:  u = '{ncr_pkg::OP_ADD, ncr_pkg::SRC_T,    ncr_pkg::SRC_C2,   ncr_pkg::DST_T};
			4'd6:  u = '{ncr_pkg::OP_MUL, ncr_pkg::SRC_T,    ncr_pkg::SRC_X,    ncr_pkg::DST_T};
			4'd7:  u = '{ncr_pkg::OP_ADD, ncr_pkg::SRC_T,    ncr_pkg::SRC_C1,   ncr_pkg::DST_T};
			4'd8:  u = '{ncr_pkg::OP_MUL, ncr_pkg::SRC_T,    ncr_pkg::SRC_X,    ncr_pkg::DST_T};
			4'd9:  u = '{ncr_pkg::OP_ADD, ncr_pkg::SRC_T,    ncr_pkg::SRC_C0,   ncr_pkg::DST_FX};
			4'd10: u = '{ncr_pkg::OP_MUL, ncr_pkg::SRC_C3X3, ncr_pkg::SRC_X,    ncr_pkg::DST_T};
			4'd11: u = '{ncr_pkg::OP_ADD, ncr_pkg::SRC_T,    ncr_pkg::SRC_C2X2, ncr_pkg::DST_T};
			4'd12: u = '{ncr_pkg::OP_MUL, ncr_pkg::SRC_T,    ncr_pkg::SRC_X,    ncr_pkg::DST_T};
			4'd13: u = '{ncr_pkg::OP_ADD, ncr_pkg::SRC_T,    ncr_pkg::SRC_C1,   ncr_pkg::DST_DFX};
			4'd14: u = '{ncr_pkg::OP_MUL, ncr_pkg::SRC_C6,   ncr_pkg::SRC_X,    ncr_pkg::DST_T};
			4'd15: u = '{ncr_pkg::OP_ADD, ncr_pkg::SRC_T,    ncr_pkg::SRC_C2X2, ncr_pkg::DST_DDFX};
		endcase
		return u;
	endfunction

	// f and f'' both nonzero with the same sign
	assign ss = (fx_q > 0 && ddfx_q > 0) || (fx_q < 0 && ddfx_q < 0);

	assign cur = (state_q == ncr_pkg::ST_SUB) ?
		ncr_pkg::uop_t'{ncr_pkg::OP_SUB, ncr_pkg::SRC_X, ncr_pkg::SRC_Q, ncr_pkg::DST_XN} :
		uop_rom(step_q);

	// operand bank, indexed by source code
	always_comb begin
		for (int i = 0; i < 16; i++)
			bank[i] = '0;
		bank[ncr_pkg::SRC_C3]   = c3_q;
		bank[ncr_pkg::SRC_C2]   = c2_q;
		bank[ncr_pkg::SRC_C1]   = c1_q;
		bank[ncr_pkg::SRC_C0]   = c0_q;
		bank[ncr_pkg::SRC_X]    = x_q;
		bank[ncr_pkg::SRC_T]    = t_q;
		bank[ncr_pkg::SRC_C3X3] = c3x3_q;
		bank[ncr_pkg::SRC_C2X2] = c2x2_q;
		bank[ncr_pkg::SRC_C6]   = c6_q;
		bank[ncr_pkg::SRC_Q]    = q_q;
	end

	assign a_val = bank[cur.a];
	assign b_val = bank[cur.b];

	// shared arithmetic unit: magnitude product truncates toward zero
	assign prod = ncr_pkg::mag_of(a_val) * ncr_pkg::mag_of(b_val);

	always_comb begin
		unique case (cur.op)
			ncr_pkg::OP_MUL: alu_res = ncr_pkg::sat_mag(a_val[DW-1] ^ b_val[DW-1],
				prod >> ncr_pkg::FB);
			ncr_pkg::OP_SUB: alu_res = ncr_pkg::sat_sum({a_val[DW-1], a_val} -
				{b_val[DW-1], b_val});
			ncr_pkg::OP_ADD: alu_res = ncr_pkg::sat_sum({a_val[DW-1], a_val} +
				{b_val[DW-1], b_val});
			default:         alu_res = '0;
		endcase
	end

	ncr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (fx_q),
		.den    (dfx_q),
		.res    (div_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ncr_pkg::ST_IDLE:  if (in_valid) state_d = ncr_pkg::ST_PRO;
			ncr_pkg::ST_PRO:   if (step_q == ncr_pkg::PRO_LAST) state_d = ncr_pkg::ST_EVAL;
			ncr_pkg::ST_EVAL:  if (step_q == ncr_pkg::EVAL_LAST) state_d = ncr_pkg::ST_CHECK;
			ncr_pkg::ST_CHECK: begin
				unique case (ph_q)
					ncr_pkg::PH_A: state_d = ss ? ncr_pkg::ST_LOOP : ncr_pkg::ST_EVAL;
					ncr_pkg::PH_B: state_d = ss ? ncr_pkg::ST_LOOP : ncr_pkg::ST_FIN;
					default:       state_d = ncr_pkg::ST_DIV;
				endcase
			end
			ncr_pkg::ST_LOOP:  state_d = (steps_q == max_it_q) ? ncr_pkg::ST_FIN : ncr_pkg::ST_EVAL;
			ncr_pkg::ST_DIV:   if (div_res.done) state_d = ncr_pkg::ST_SUB;
			ncr_pkg::ST_SUB:   state_d = ss ? ncr_pkg::ST_LOOP : ncr_pkg::ST_FIN;
			ncr_pkg::ST_FIN:   if (!out_valid_q || !out_stall) state_d = ncr_pkg::ST_IDLE;
			default:           state_d = ncr_pkg::ST_IDLE;
		endcase
	end

	// control strobes
	always_comb begin
		ld_in      = state_q == ncr_pkg::ST_IDLE && in_valid;
		alu_wr     = state_q == ncr_pkg::ST_PRO || state_q == ncr_pkg::ST_EVAL;
		take_b     = state_q == ncr_pkg::ST_CHECK && ph_q == ncr_pkg::PH_A && !ss;
		no_start   = state_q == ncr_pkg::ST_CHECK && ph_q == ncr_pkg::PH_B && !ss;
		keep_start = state_q == ncr_pkg::ST_CHECK && ph_q != ncr_pkg::PH_X && ss;
		div_start  = state_q == ncr_pkg::ST_CHECK && ph_q == ncr_pkg::PH_X;
		iter_next  = state_q == ncr_pkg::ST_LOOP && steps_q != max_it_q;
		div_take   = state_q == ncr_pkg::ST_DIV && div_res.done;
		sub_wr     = state_q == ncr_pkg::ST_SUB;
		out_ld     = state_q == ncr_pkg::ST_FIN && (!out_valid_q || !out_stall);
	end

	assign in_stall  = state_q != ncr_pkg::ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// control registers and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ncr_pkg::ST_IDLE;
			ph_q        <= ncr_pkg::PH_A;
			step_q      <= '0;
			steps_q     <= '0;
			sat_q       <= 1'b0;
			nostart_q   <= 1'b0;
			out_valid_q <= 1'b0;
			c3_q        <= ncr_pkg::RST_CUBIC;
			c2_q        <= ncr_pkg::RST_SQUARE;
			c1_q        <= ncr_pkg::RST_LINEAR;
			c0_q        <= ncr_pkg::RST_CONST;
			max_it_q    <= ncr_pkg::RST_MAXIT;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					ncr_pkg::REG_CUBIC:  c3_q <= cfg_wdata;
					ncr_pkg::REG_SQUARE: c2_q <= cfg_wdata;
					ncr_pkg::REG_LINEAR: c1_q <= cfg_wdata;
					ncr_pkg::REG_CONST:  c0_q <= cfg_wdata;
					ncr_pkg::REG_MAXIT:  max_it_q <= cfg_wdata[5:0];
					default: ;
				endcase
			end
			if (ld_in) begin
				step_q    <= '0;
				steps_q   <= '0;
				sat_q     <= 1'b0;
				nostart_q <= 1'b0;
				ph_q      <= ncr_pkg::PH_A;
			end
			if (alu_wr) begin
				step_q <= step_q + 1'b1;
				sat_q  <= sat_q | alu_res.sat;
			end
			if (take_b) begin
				step_q <= ncr_pkg::EVAL_FIRST;
				ph_q   <= ncr_pkg::PH_B;
			end
			if (no_start)
				nostart_q <= 1'b1;
			if (iter_next) begin
				step_q <= ncr_pkg::EVAL_FIRST;
				ph_q   <= ncr_pkg::PH_X;
			end
			if (div_take)
				sat_q <= sat_q | div_res.sat;
			if (sub_wr) begin
				steps_q <= steps_q + 1'b1;
				sat_q   <= sat_q | alu_res.sat;
			end
			if (out_ld)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (ld_in) begin
			x_q <= in_data.left_end;
			b_q <= in_data.right_end;
		end
		if (alu_wr || sub_wr) begin
			unique case (cur.d)
				ncr_pkg::DST_T:    t_q    <= alu_res.val;
				ncr_pkg::DST_FX:   fx_q   <= alu_res.val;
				ncr_pkg::DST_DFX:  dfx_q  <= alu_res.val;
				ncr_pkg::DST_DDFX: ddfx_q <= alu_res.val;
				ncr_pkg::DST_C3X3: c3x3_q <= alu_res.val;
				ncr_pkg::DST_C2X2: c2x2_q <= alu_res.val;
				ncr_pkg::DST_C6:   c6_q   <= alu_res.val;
				ncr_pkg::DST_XN:   xn_q   <= alu_res.val;
				default: ;
			endcase
		end
		if (sub_wr && ss)
			x_q <= alu_res.val;
		if (take_b)
			x_q <= b_q;
		if (keep_start)
			xn_q <= x_q;
		if (div_take)
			q_q <= div_res.quo;
		if (out_ld) begin
			out_q.root       <= nostart_q ? '0 : xn_q;
			out_q.status     <= nostart_q ? ncr_pkg::STAT_NOSTART :
				(sat_q ? ncr_pkg::STAT_FAULT : ncr_pkg::STAT_OK);
			out_q.steps_done <= nostart_q ? '0 : steps_q;
		end
	end

	`NCR_ASSERT(a_nostart_word, clk, arst_n, out_valid_q && out_q.status == ncr_pkg::STAT_NOSTART |-> out_q.root == '0 && out_q.steps_done == '0, "refused solve carries root or steps")
	`NCR_ASSERT(a_step_limit, clk, arst_n, state_q != ncr_pkg::ST_IDLE |-> steps_q <= max_it_q, "step count passed the limit")
	`NCR_ASSERT(a_div_owner, clk, arst_n, div_res.done |-> state_q == ncr_pkg::ST_DIV, "quotient arrived outside the divide wait")
	`NCR_ASSERT(a_out_steps, clk, arst_n, out_valid_q |-> out_q.steps_done <= max_it_q, "result reports more steps than allowed")

endmodule
